/* hw/rtl/serial_frame_parser_sum_add_check_core_assert.svh */
// Assertion shorthands for the frame parser core.
// Each expects clk and rst_n to be visible where it is used.
`ifndef SERIAL_FRAME_PARSER_SUM_ADD_CHECK_CORE_ASSERT_SVH
`define SERIAL_FRAME_PARSER_SUM_ADD_CHECK_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define SFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfp: implication failed");

// Condition must hold in the cycle after the trigger.
`define SFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfp: next-cycle check failed");

`endif

/* hw/rtl/sfp_pkg.sv */
package sfp_pkg;

  localparam int CAPTURE_DEPTH = 12;
  localparam int CAP_IDX_W     = $clog2(CAPTURE_DEPTH);
  localparam int NUM_WORDS     = CAPTURE_DEPTH / 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TELEMETRY_ID = 2'd2;

  localparam logic [7:0] RST_SYNC_FIRST   = 8'hAA;
  localparam logic [7:0] RST_SYNC_SECOND  = 8'hFF;
  localparam logic [7:0] RST_TELEMETRY_ID = 8'hF5;

  // result status codes
  localparam logic [1:0] ST_BAD   = 2'd0;
  localparam logic [1:0] ST_GOOD  = 2'd1;
  localparam logic [1:0] ST_TELEM = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SUM     = 3'd5,
    PH_ADD     = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] telemetry_id;
  } sfp_cfg_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         frame_id;
    logic [7:0]         payload_length;
    logic signed [15:0] angle_right;
    logic signed [15:0] angle_left;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    logic signed [15:0] voltage_centivolts;
  } sfp_result_t;

endpackage

/* hw/rtl/sfp_cfg_regs.sv */
module sfp_cfg_regs import sfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output sfp_cfg_t              cfg
);

  sfp_cfg_t cfg_r;
  sfp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:   cfg_nxt.sync_first   = cfg_wdata;
        CFG_SYNC_SECOND:  cfg_nxt.sync_second  = cfg_wdata;
        CFG_TELEMETRY_ID: cfg_nxt.telemetry_id = cfg_wdata;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first   <= RST_SYNC_FIRST;
      cfg_r.sync_second  <= RST_SYNC_SECOND;
      cfg_r.telemetry_id <= RST_TELEMETRY_ID;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/sfp_parser.sv */
module sfp_parser import sfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  sfp_cfg_t    cfg,
  input  logic        byte_acc,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output sfp_result_t res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_id_r, held_id_nxt;
  logic [7:0] decl_len_r, decl_len_nxt;
  logic [7:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] add_r, add_nxt;
  logic [7:0] rx_sum_r, rx_sum_nxt;
  logic [7:0] cap_r [CAPTURE_DEPTH];

  logic [7:0]           sum_abs, add_abs, cnt_inc;
  logic                 cap_we;
  logic [CAP_IDX_W-1:0] cap_idx;
  logic                 chk_ok, is_telem;
  logic [15:0]          words [NUM_WORDS];

  // running sum/add update for the current byte
  assign sum_abs = sum_r + rx_byte;
  assign add_abs = add_r + sum_abs;
  assign cnt_inc = byte_cnt_r + 8'd1;
  assign cap_idx = byte_cnt_r[CAP_IDX_W-1:0];

  always_comb begin
    phase_nxt    = phase_r;
    held_id_nxt  = held_id_r;
    decl_len_nxt = decl_len_r;
    byte_cnt_nxt = byte_cnt_r;
    sum_nxt      = sum_r;
    add_nxt      = add_r;
    rx_sum_nxt   = rx_sum_r;
    cap_we       = 1'b0;
    res_valid    = 1'b0;
    if (byte_acc) begin
      unique case (phase_r)
        PH_HUNT: begin
          decl_len_nxt = '0;
          byte_cnt_nxt = '0;
          sum_nxt      = '0;
          add_nxt      = '0;
          if (rx_byte == cfg.sync_first) begin
            // sum and add both start from zero
            sum_nxt   = rx_byte;
            add_nxt   = rx_byte;
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (rx_byte == cfg.sync_second) begin
            sum_nxt   = sum_abs;
            add_nxt   = add_abs;
            phase_nxt = PH_ID;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_ID: begin
          held_id_nxt = rx_byte;
          sum_nxt     = sum_abs;
          add_nxt     = add_abs;
          phase_nxt   = PH_LEN;
        end
        PH_LEN: begin
          decl_len_nxt = rx_byte;
          byte_cnt_nxt = '0;
          sum_nxt      = sum_abs;
          add_nxt      = add_abs;
          phase_nxt    = (rx_byte == 8'd0) ? PH_SUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          cap_we       = (byte_cnt_r < 8'(CAPTURE_DEPTH));
          sum_nxt      = sum_abs;
          add_nxt      = add_abs;
          byte_cnt_nxt = cnt_inc;
          if (cnt_inc >= decl_len_r) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          rx_sum_nxt = rx_byte;
          phase_nxt  = PH_ADD;
        end
        PH_ADD: begin
          res_valid = 1'b1;
          phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      held_id_r  <= '0;
      decl_len_r <= '0;
      byte_cnt_r <= '0;
      sum_r      <= '0;
      add_r      <= '0;
      rx_sum_r   <= '0;
    end else begin
      phase_r    <= phase_nxt;
      held_id_r  <= held_id_nxt;
      decl_len_r <= decl_len_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      sum_r      <= sum_nxt;
      add_r      <= add_nxt;
      rx_sum_r   <= rx_sum_nxt;
    end
  end

  // capture bytes hold no reset; a telemetry frame always overwrites all of them
  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_r[cap_idx] <= rx_byte;
    end
  end

  for (genvar w = 0; w < NUM_WORDS; w++) begin : g_word
    assign words[w] = {cap_r[2*w+1], cap_r[2*w]};
  end

  assign chk_ok   = (rx_sum_r == sum_r) && (rx_byte == add_r);
  assign is_telem = chk_ok && (held_id_r == cfg.telemetry_id)
                    && (decl_len_r >= 8'(CAPTURE_DEPTH));

  always_comb begin
    res                = '0;
    res.frame_id       = held_id_r;
    res.payload_length = decl_len_r;
    if (!chk_ok) begin
      res.status = ST_BAD;
    end else if (is_telem) begin
      res.status             = ST_TELEM;
      res.angle_right        = words[0];
      res.angle_left         = words[1];
      res.pitch              = words[2];
      res.roll               = words[3];
      res.yaw                = words[4];
      res.voltage_centivolts = words[5];
    end else begin
      res.status = ST_GOOD;
    end
  end

endmodule

/* hw/rtl/sfp_out_buf.sv */
module sfp_out_buf import sfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sfp_result_t push_data,
  input  logic        out_stall,
  output logic        out_valid,
  output sfp_result_t head,
  output logic        full
);

  logic        head_vld_r, head_vld_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  sfp_result_t head_r, head_nxt;
  sfp_result_t skid_r, skid_nxt;
  logic        head_free;

  assign head_free = !head_vld_r || !out_stall;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (head_free) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        head_vld_nxt = 1'b1;
        skid_nxt     = push_data;
        skid_vld_nxt = push;
      end else begin
        head_nxt     = push_data;
        head_vld_nxt = push;
      end
    end else if (push) begin
      // head held by the receiver: park the new result
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = head_vld_r;
  assign head      = head_r;
  assign full      = skid_vld_r;

endmodule

/* hw/rtl/serial_frame_parser_sum_add_check_core.sv */
// Serial frame parser with an 8-bit sum/add check.
// Input channel: one received byte per transfer on in_rx_byte (in_valid/in_stall).
// Result channel: one transfer per completed frame (out_valid/out_stall) carrying
//   status, ID, declared length and, for telemetry frames, five int16 angles and
//   the raw battery voltage in 0.01 V counts; those six are zero otherwise.
// Config port: cfg_we with cfg_index 0..2 writes sync_first, sync_second and
//   telemetry_id; other indexes are ignored. Write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low; every byte is parsed in
//   the cycle it is taken, the frame state machine being the only loop.
// Latency: a frame's result is on the outputs the cycle after its add byte is
//   taken, unless an earlier result still waits in the output stage.
// Stall: a two-entry output stage (result register plus skid) lets bytes keep
//   flowing while a result waits; in_stall rises only when both entries are
//   occupied and drops as soon as the receiver takes one.
// Reset (rst_n low, synchronous): parser hunts for the first sync byte, the
//   checks clear, both output entries empty and the registers return to
//   0xAA, 0xFF and 0xF5.
`include "serial_frame_parser_sum_add_check_core_assert.svh"

module serial_frame_parser_sum_add_check_core import sfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  // frame results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [7:0]            out_frame_id,
  output logic [7:0]            out_payload_length,
  output logic signed [15:0]    out_angle_right,
  output logic signed [15:0]    out_angle_left,
  output logic signed [15:0]    out_pitch,
  output logic signed [15:0]    out_roll,
  output logic signed [15:0]    out_yaw,
  output logic signed [15:0]    out_voltage_centivolts,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  sfp_cfg_t    cfg;
  sfp_result_t res;
  sfp_result_t head;
  logic        res_valid;
  logic        buf_full;
  logic        byte_acc;

  // a transfer is refused only when both output entries are taken
  assign in_stall = buf_full;
  assign byte_acc = in_valid && !buf_full;

  sfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .byte_acc  (byte_acc),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfp_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .full      (buf_full)
  );

  assign out_status             = head.status;
  assign out_frame_id           = head.frame_id;
  assign out_payload_length     = head.payload_length;
  assign out_angle_right        = head.angle_right;
  assign out_angle_left         = head.angle_left;
  assign out_pitch              = head.pitch;
  assign out_roll               = head.roll;
  assign out_yaw                = head.yaw;
  assign out_voltage_centivolts = head.voltage_centivolts;

  // skid entry only fills behind an occupied result register
  `SFP_ASSERT_IMP(a_skid_behind_head, buf_full, out_valid)

  // a new result lands in the output stage on the next cycle
  `SFP_ASSERT_NEXT(a_result_lands, res_valid, out_valid)

  // status is one of the three defined codes
  `SFP_ASSERT_IMP(a_status_code, out_valid,
    out_status == ST_BAD || out_status == ST_GOOD || out_status == ST_TELEM)

  // angle_right, yaw and voltage are zero unless the frame is telemetry
  `SFP_ASSERT_IMP(a_zero_decode, out_valid && out_status != ST_TELEM,
    out_angle_right == 16'sd0 && out_yaw == 16'sd0 && out_voltage_centivolts == 16'sd0)

endmodule

/* test/sfp_frame_checker.sv */
module sfp_frame_checker import sfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            out_status,
  input  logic [7:0]            out_frame_id,
  input  logic [7:0]            out_payload_length,
  input  logic signed [15:0]    out_angle_right,
  input  logic signed [15:0]    out_angle_left,
  input  logic signed [15:0]    out_pitch,
  input  logic signed [15:0]    out_roll,
  input  logic signed [15:0]    out_yaw,
  input  logic signed [15:0]    out_voltage_centivolts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    pending
);

  sfp_cfg_t    regs;
  phase_t      phase;
  logic [7:0]  held_id;
  logic [7:0]  decl_len;
  logic [7:0]  byte_cnt;
  logic [7:0]  run_sum;
  logic [7:0]  run_add;
  logic [7:0]  rx_sum;
  logic [7:0]  capture [CAPTURE_DEPTH];
  sfp_result_t frames_due [$];

  function automatic logic signed [15:0] le_word(input int lo);
    return {capture[lo+1], capture[lo]};
  endfunction

  task automatic absorb(input logic [7:0] b);
    run_sum = run_sum + b;
    run_add = run_add + run_sum;
  endtask

  // frame parser; pushes the expected result when the add byte lands
  task automatic parse_byte(input logic [7:0] b);
    sfp_result_t r;
    case (phase)
      PH_HUNT: begin
        decl_len = '0;
        byte_cnt = '0;
        run_sum  = '0;
        run_add  = '0;
        if (b == regs.sync_first) begin
          absorb(b);
          phase = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        // a wrong byte is dropped, not retried as a first sync
        if (b == regs.sync_second) begin
          absorb(b);
          phase = PH_ID;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_ID: begin
        held_id = b;
        absorb(b);
        phase = PH_LEN;
      end
      PH_LEN: begin
        decl_len = b;
        byte_cnt = '0;
        absorb(b);
        phase = (b == 8'd0) ? PH_SUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (byte_cnt < CAPTURE_DEPTH) capture[byte_cnt] = b;
        absorb(b);
        byte_cnt = byte_cnt + 8'd1;
        if (byte_cnt >= decl_len) phase = PH_SUM;
      end
      PH_SUM: begin
        rx_sum = b;
        phase = PH_ADD;
      end
      PH_ADD: begin
        r = '0;
        r.frame_id       = held_id;
        r.payload_length = decl_len;
        if (rx_sum != run_sum || b != run_add) begin
          r.status = ST_BAD;
        end else if (held_id == regs.telemetry_id && decl_len >= CAPTURE_DEPTH) begin
          r.status             = ST_TELEM;
          r.angle_right        = le_word(0);
          r.angle_left         = le_word(2);
          r.pitch              = le_word(4);
          r.roll               = le_word(6);
          r.yaw                = le_word(8);
          r.voltage_centivolts = le_word(10);
        end else begin
          r.status = ST_GOOD;
        end
        frames_due.push_back(r);
        phase = PH_HUNT;
      end
      default: phase = PH_HUNT;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("frame mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic check_result();
    sfp_result_t want;
    if (frames_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("frame mismatch: result transfer with none expected (id %h)", out_frame_id);
      return;
    end
    want = frames_due.pop_front();
    check_field("status", 16'(want.status), 16'(out_status));
    check_field("frame_id", 16'(want.frame_id), 16'(out_frame_id));
    check_field("payload_length", 16'(want.payload_length), 16'(out_payload_length));
    check_field("angle_right", want.angle_right, out_angle_right);
    check_field("angle_left", want.angle_left, out_angle_left);
    check_field("pitch", want.pitch, out_pitch);
    check_field("roll", want.roll, out_roll);
    check_field("yaw", want.yaw, out_yaw);
    check_field("voltage_centivolts", want.voltage_centivolts, out_voltage_centivolts);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.sync_first   = RST_SYNC_FIRST;
      regs.sync_second  = RST_SYNC_SECOND;
      regs.telemetry_id = RST_TELEMETRY_ID;
      phase    = PH_HUNT;
      held_id  = '0;
      decl_len = '0;
      byte_cnt = '0;
      run_sum  = '0;
      run_add  = '0;
      rx_sum   = '0;
      for (int i = 0; i < CAPTURE_DEPTH; i++) capture[i] = '0;
      frames_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_FIRST:   regs.sync_first   = cfg_wdata;
          CFG_SYNC_SECOND:  regs.sync_second  = cfg_wdata;
          CFG_TELEMETRY_ID: regs.telemetry_id = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) parse_byte(in_rx_byte);
    end
    pending = frames_due.size();
  end

endmodule

/* test/tb_serial_frame_parser_sum_add_check_core.sv */
// Stimulus and verdict for the frame parser. The checker beside the block
// does all prediction and comparison; this module only feeds bytes, writes
// the sync/telemetry registers between phases and throttles the result side.
module tb_serial_frame_parser_sum_add_check_core;
  import sfp_pkg::*;

  // index 3 decodes to nothing; writing it must leave every register alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_ADD, FLAW_BOTH} flaw_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [1:0]            out_status;
  logic [7:0]            out_frame_id;
  logic [7:0]            out_payload_length;
  logic signed [15:0]    out_angle_right;
  logic signed [15:0]    out_angle_left;
  logic signed [15:0]    out_pitch;
  logic signed [15:0]    out_roll;
  logic signed [15:0]    out_yaw;
  logic signed [15:0]    out_voltage_centivolts;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int mismatches;
  int frames_pending;

  // register values as last written, so frames can be built to match them
  logic [7:0] cur_sf  = RST_SYNC_FIRST;
  logic [7:0] cur_ss  = RST_SYNC_SECOND;
  logic [7:0] cur_tid = RST_TELEMETRY_ID;

  int gap_pct    = 0;   // chance of a sender gap after each transfer
  int stall_pct  = 0;   // chance of the receiver starting a stall run
  int stall_left = 0;
  int large_left = 3;   // near-maximum random frames still allowed
  int bytes_sent = 0;

  logic [7:0] frame_body [$];

  serial_frame_parser_sum_add_check_core uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rx_byte             (in_rx_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_frame_id           (out_frame_id),
    .out_payload_length     (out_payload_length),
    .out_angle_right        (out_angle_right),
    .out_angle_left         (out_angle_left),
    .out_pitch              (out_pitch),
    .out_roll               (out_roll),
    .out_yaw                (out_yaw),
    .out_voltage_centivolts (out_voltage_centivolts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  sfp_frame_checker chk (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rx_byte             (in_rx_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_frame_id           (out_frame_id),
    .out_payload_length     (out_payload_length),
    .out_angle_right        (out_angle_right),
    .out_angle_left         (out_angle_left),
    .out_pitch              (out_pitch),
    .out_roll               (out_roll),
    .out_yaw                (out_yaw),
    .out_voltage_centivolts (out_voltage_centivolts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .mismatches             (mismatches),
    .pending                (frames_pending)
  );

  always #5 clk = ~clk;

  // run length for sender gaps and receiver stalls: usually short, now and then long
  function automatic int pick_run_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver back-pressure: runs of stall independent of out_valid.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= pick_run_len() - 1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // One byte transfer. Valid stays up into the next call when there is no
  // gap, so it is never dropped and raised within the same step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = pick_run_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until every expected result has been taken, then lets
  // the output stage settle. Sampled on the falling edge to stay clear of
  // the checker's update. Returns on a rising edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (frames_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called with the block idle (after drain or straight after reset).
  task automatic set_regs(input logic [7:0] sf, input logic [7:0] ss,
                          input logic [7:0] tid);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_wdata <= sf;
    @(posedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_wdata <= ss;
    @(posedge clk);
    cfg_index <= CFG_TELEMETRY_ID;
    cfg_wdata <= tid;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= 8'($urandom_range(0, 255));
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_sf  = sf;
    cur_ss  = ss;
    cur_tid = tid;
  endtask

  task automatic fill_body(input int len);
    frame_body.delete();
    repeat (len) frame_body.push_back(8'($urandom_range(0, 255)));
  endtask

  // Whole frame around frame_body: both sync bytes, ID, length, payload,
  // then the sum and add bytes, either of which may be spoilt on purpose.
  task automatic send_frame(input logic [7:0] id, input flaw_t flaw);
    logic [7:0] hdr [4];
    logic [7:0] s;
    logic [7:0] a;
    hdr[0] = cur_sf;
    hdr[1] = cur_ss;
    hdr[2] = id;
    hdr[3] = 8'(frame_body.size());
    s = '0;
    a = '0;
    foreach (hdr[i]) begin
      s = s + hdr[i];
      a = a + s;
    end
    foreach (frame_body[i]) begin
      s = s + frame_body[i];
      a = a + s;
    end
    if (flaw == FLAW_SUM || flaw == FLAW_BOTH) s = s ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_ADD || flaw == FLAW_BOTH) a = a ^ 8'($urandom_range(1, 255));
    foreach (hdr[i]) send_byte(hdr[i]);
    foreach (frame_body[i]) send_byte(frame_body[i]);
    send_byte(s);
    send_byte(a);
  endtask

  // Mostly well-formed frames with random content; the rest is broken
  // syncs, checksum errors and line noise.
  task automatic send_random_item();
    int         pick;
    int         len;
    int         n;
    logic [7:0] id;
    logic [7:0] b;
    flaw_t      flaw;
    pick = $urandom_range(0, 99);
    id   = 8'($urandom_range(0, 255));
    len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 16);
    flaw = FLAW_NONE;
    if (pick < 45) begin
      if ($urandom_range(0, 9) == 0) id = cur_tid;
    end else if (pick < 65) begin
      // telemetry ID either side of the twelve-byte threshold
      id  = cur_tid;
      len = $urandom_range(10, 20);
    end else if (pick < 80) begin
      flaw = flaw_t'($urandom_range(1, 3));
      if ($urandom_range(0, 1) == 1) id = cur_tid;
    end else if (pick < 90) begin
      // first sync then anything but the second; sometimes a repeat of the
      // first, which must not restart the frame
      send_byte(cur_sf);
      do b = 8'($urandom_range(0, 255)); while (b == cur_ss);
      if (cur_sf != cur_ss && $urandom_range(0, 1) == 1) b = cur_sf;
      send_byte(b);
      return;
    end else if (pick < 98 || large_left == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      return;
    end else begin
      large_left--;
      len = $urandom_range(200, 254);
      if ($urandom_range(0, 1) == 1) flaw = FLAW_SUM;
    end
    fill_body(len);
    send_frame(id, flaw);
  endtask

  task automatic run_random(input int target, input bit pause_midway);
    int start;
    bit paused;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < target) begin
      if (pause_midway && !paused && bytes_sent - start >= target / 2) begin
        paused = 1'b1;
        drain();
        // longest frame the length byte allows, good telemetry
        fill_body(255);
        send_frame(cur_tid, FLAW_NONE);
      end
      send_random_item();
    end
  endtask

  initial begin
    logic [7:0] v;
    gap_pct   = 20;
    stall_pct = 20;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: repeated first sync in place of the second (dropped), a
    // zero-length frame with the top ID, then telemetry with signed extremes.
    send_byte(cur_sf);
    send_byte(cur_sf);
    frame_body.delete();
    send_frame(8'hFF, FLAW_NONE);
    frame_body = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF,
                   8'h00, 8'h00, 8'h01, 8'h00, 8'h34, 8'h12};
    send_frame(cur_tid, FLAW_NONE);

    // reset register values, with the sender pausing once part way
    run_random(400, 1'b1);
    drain();

    // all-zero first sync and ID, no idling on either side
    gap_pct   = 0;
    stall_pct = 0;
    set_regs(8'h00, 8'hFF, 8'h00);
    run_random(300, 1'b0);
    drain();

    // all-ones first sync and ID, heavy idling
    gap_pct   = 40;
    stall_pct = 50;
    set_regs(8'hFF, 8'h00, 8'hFF);
    run_random(300, 1'b0);
    drain();

    gap_pct   = 15;
    stall_pct = 15;
    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
    run_random(250, 1'b0);
    drain();

    // both sync bytes equal
    v = 8'($urandom_range(0, 255));
    set_regs(v, v, 8'($urandom_range(0, 255)));
    run_random(150, 1'b0);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && frames_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sfp_pkg.sv
hw/rtl/sfp_cfg_regs.sv
hw/rtl/sfp_parser.sv
hw/rtl/sfp_out_buf.sv
hw/rtl/serial_frame_parser_sum_add_check_core.sv
test/sfp_frame_checker.sv
test/tb_serial_frame_parser_sum_add_check_core.sv
